// ===== src/dtm_pkg.sv =====
`default_nettype none
package dtm_pkg;
   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_ADD        = 3'd1;
   localparam logic [2:0] KIND_REMOVE     = 3'd2;
   localparam logic [2:0] KIND_REMOVE_WIN = 3'd3;
   localparam logic [2:0] KIND_SET_LEGACY = 3'd4;
   localparam logic [2:0] KIND_CLR_LEGACY = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_IVL  = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic [31:0] window_id;
      logic [31:0] interval_ms;
      logic        periodic;
      logic [31:0] target_handle;
   } cmd_type;

   typedef struct packed {
      logic        is_event;
      logic [31:0] event_window;
      logic [31:0] handle_out;
      logic [31:0] next_deadline;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/dtm_front.sv =====
`default_nettype none
module dtm_front
   import dtm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire cmd_type req_cmd,
   output logic         q_valid,
   input  wire logic    q_pop,
   output cmd_type      q_cmd
);
   // Two-entry queue; unknown kinds are dropped on entry.
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, keep;

   assign req_stall = (cnt_ff == 2'd2);
   assign keep = (req_cmd.kind == KIND_TICK) || (req_cmd.kind == KIND_ADD) ||
                 (req_cmd.kind == KIND_REMOVE) || (req_cmd.kind == KIND_REMOVE_WIN) ||
                 (req_cmd.kind == KIND_SET_LEGACY) || (req_cmd.kind == KIND_CLR_LEGACY);
   assign push = req_valid && !req_stall && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= req_cmd;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/dtm_back.sv =====
`default_nettype none
module dtm_back
   import dtm_pkg::*;
#(
   parameter int TIMER_SLOTS = 16
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   output logic         q_pop,
   input  wire cmd_type q_cmd,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_rsp
);
   localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CW-1:0] LAST_SLOT = CW'(TIMER_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FIRE   = 3'd2;
   localparam logic [2:0] ST_MIN    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_LEGACY = 3'd5;

   logic [TIMER_SLOTS-1:0] valid_ff, due_ff;
   logic [31:0] handle_ff   [TIMER_SLOTS];
   logic [31:0] window_ff   [TIMER_SLOTS];
   logic [31:0] interval_ff [TIMER_SLOTS];
   logic [31:0] deadline_ff [TIMER_SLOTS];
   logic        periodic_ff [TIMER_SLOTS];

   logic [31:0] next_handle_ff, leg_window_ff, leg_interval_ff, leg_last_ff;
   logic [2:0]  state_ff;
   cmd_type     cmd_ff;
   logic [CW-1:0] idx_ff;
   logic [SW-1:0] idx;
   logic        best_any_ff;
   logic [SW-1:0] best_ff;
   logic [31:0] best_dl_ff, best_h_ff, min_ff, nd_ff;
   logic        min_any_ff;
   logic        ov_ff, ov_in;
   rsp_type     ov_rsp_ff, pend_ff, rsp;
   logic        emit, can_emit;
   logic        beats;
   logic [31:0] elapsed;

   // Closing word of an item: no event, last set.
   function automatic rsp_type done_word(logic [1:0] st, logic [31:0] h, logic [31:0] nd);
      rsp_type r;
      r = '0;
      r.handle_out = h;
      r.next_deadline = nd;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   assign idx = idx_ff[SW-1:0];
   assign can_emit = !ov_ff || !out_stall;
   assign out_valid = ov_ff;
   assign out_rsp = ov_rsp_ff;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign elapsed = cmd_ff.now_ms - leg_last_ff;
   assign beats = !best_any_ff || (deadline_ff[idx] < best_dl_ff) ||
                  (deadline_ff[idx] == best_dl_ff && handle_ff[idx] < best_h_ff);
   assign ov_in = (emit && can_emit) || (ov_ff && out_stall);

   always_comb begin
      rsp = '0;
      emit = 1'b0;
      unique case (state_ff)
         ST_LEGACY: begin
            rsp.is_event = 1'b1;
            rsp.event_window = leg_window_ff;
            emit = (leg_interval_ff != 32'd0) && (elapsed >= leg_interval_ff);
         end
         ST_FIRE: begin
            rsp.is_event = 1'b1;
            rsp.event_window = window_ff[best_ff];
            rsp.handle_out = handle_ff[best_ff];
            emit = best_any_ff;
         end
         ST_EMIT: begin
            rsp = pend_ff;
            emit = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         next_handle_ff <= 32'd1;
         leg_window_ff <= '0;
         leg_interval_ff <= '0;
         leg_last_ff <= '0;
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (emit && can_emit) ov_rsp_ff <= rsp;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_cmd;
                  idx_ff <= '0;
                  best_any_ff <= 1'b0;
                  min_any_ff <= 1'b0;
                  nd_ff <= '0;
                  state_ff <= (q_cmd.kind == KIND_TICK) ? ST_LEGACY : ST_SCAN;
               end
            end
            ST_LEGACY: begin
               // Fires the legacy timer if due; records its next deadline whenever it is armed.
               if (leg_interval_ff == 32'd0) begin
                  state_ff <= ST_SCAN;
               end else if (elapsed >= leg_interval_ff) begin
                  if (can_emit) begin
                     leg_last_ff <= cmd_ff.now_ms;
                     nd_ff <= cmd_ff.now_ms + leg_interval_ff;
                     state_ff <= ST_SCAN;
                  end
               end else begin
                  nd_ff <= leg_last_ff + leg_interval_ff;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // One slot per cycle.
               unique case (cmd_ff.kind)
                  KIND_TICK: begin
                     due_ff[idx] <= valid_ff[idx] && deadline_ff[idx] <= cmd_ff.now_ms;
                     if (idx_ff == LAST_SLOT) begin
                        idx_ff <= '0;
                        state_ff <= ST_MIN;
                        best_any_ff <= 1'b0;
                     end else idx_ff <= idx_ff + 1'b1;
                  end
                  KIND_ADD: begin
                     if (cmd_ff.interval_ms == 32'd0) begin
                        pend_ff <= done_word(STATUS_ZERO_IVL, 32'd0, 32'd0);
                        state_ff <= ST_EMIT;
                     end else if (!valid_ff[idx]) begin
                        valid_ff[idx] <= 1'b1;
                        handle_ff[idx] <= next_handle_ff;
                        window_ff[idx] <= cmd_ff.window_id;
                        interval_ff[idx] <= cmd_ff.interval_ms;
                        deadline_ff[idx] <= cmd_ff.now_ms + cmd_ff.interval_ms;
                        periodic_ff[idx] <= cmd_ff.periodic;
                        next_handle_ff <= (next_handle_ff == 32'hFFFF_FFFF) ? 32'd1 :
                                          next_handle_ff + 32'd1;
                        pend_ff <= done_word(STATUS_OK, next_handle_ff, 32'd0);
                        state_ff <= ST_EMIT;
                     end else if (idx_ff == LAST_SLOT) begin
                        pend_ff <= done_word(STATUS_FULL, 32'd0, 32'd0);
                        state_ff <= ST_EMIT;
                     end else idx_ff <= idx_ff + 1'b1;
                  end
                  KIND_REMOVE: begin
                     if (valid_ff[idx] && handle_ff[idx] == cmd_ff.target_handle) begin
                        valid_ff[idx] <= 1'b0;
                        pend_ff <= done_word(STATUS_OK, 32'd0, 32'd0);
                        state_ff <= ST_EMIT;
                     end else if (idx_ff == LAST_SLOT) begin
                        pend_ff <= done_word(STATUS_NOT_FOUND, 32'd0, 32'd0);
                        state_ff <= ST_EMIT;
                     end else idx_ff <= idx_ff + 1'b1;
                  end
                  KIND_REMOVE_WIN: begin
                     if (window_ff[idx] == cmd_ff.window_id) valid_ff[idx] <= 1'b0;
                     if (idx_ff == LAST_SLOT) begin
                        pend_ff <= done_word(STATUS_OK, 32'd0, 32'd0);
                        state_ff <= ST_EMIT;
                     end else idx_ff <= idx_ff + 1'b1;
                  end
                  KIND_SET_LEGACY: begin
                     leg_window_ff <= cmd_ff.window_id;
                     leg_interval_ff <= cmd_ff.interval_ms;
                     leg_last_ff <= cmd_ff.now_ms;
                     pend_ff <= done_word(STATUS_OK, 32'd0, 32'd0);
                     state_ff <= ST_EMIT;
                  end
                  default: begin
                     leg_interval_ff <= '0;
                     pend_ff <= done_word(STATUS_OK, 32'd0, 32'd0);
                     state_ff <= ST_EMIT;
                  end
               endcase
            end
            ST_MIN: begin
               // Searches the earliest due slot, one slot per cycle.
               if (due_ff[idx] && beats) begin
                  best_any_ff <= 1'b1;
                  best_ff <= idx;
                  best_dl_ff <= deadline_ff[idx];
                  best_h_ff <= handle_ff[idx];
               end
               if (idx_ff == LAST_SLOT) begin
                  idx_ff <= '0;
                  state_ff <= ST_FIRE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            ST_FIRE: begin
               if (!best_any_ff) begin
                  // Final pass for the closing word: earliest valid deadline, or the legacy deadline if sooner.
                  if (valid_ff[idx] && (!min_any_ff || deadline_ff[idx] < min_ff)) begin
                     min_any_ff <= 1'b1;
                     min_ff <= deadline_ff[idx];
                  end
                  if (idx_ff == LAST_SLOT) begin
                     if (valid_ff[idx] && (!min_any_ff || deadline_ff[idx] < min_ff)) begin
                        if (nd_ff == 32'd0 || deadline_ff[idx] < nd_ff)
                           pend_ff <= done_word(STATUS_OK, 32'd0, deadline_ff[idx]);
                        else pend_ff <= done_word(STATUS_OK, 32'd0, nd_ff);
                     end else if (min_any_ff && (nd_ff == 32'd0 || min_ff < nd_ff)) begin
                        pend_ff <= done_word(STATUS_OK, 32'd0, min_ff);
                     end else pend_ff <= done_word(STATUS_OK, 32'd0, nd_ff);
                     state_ff <= ST_EMIT;
                  end else idx_ff <= idx_ff + 1'b1;
               end else if (can_emit) begin
                  due_ff[best_ff] <= 1'b0;
                  if (periodic_ff[best_ff])
                     deadline_ff[best_ff] <= cmd_ff.now_ms + interval_ff[best_ff];
                  else valid_ff[best_ff] <= 1'b0;
                  best_any_ff <= 1'b0;
                  idx_ff <= '0;
                  state_ff <= ST_MIN;
               end
            end
            ST_EMIT: begin
               if (can_emit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/deadline_timer_manager.sv =====
`default_nettype none
// Control words that search the slot table scan it one slot a cycle.
// A tick checks the legacy timer, marks due slots, then runs the serial minimum search
// over the slot table before each firing timer and once more, then a closing pass
// for its next deadline; result stalls hold it up.
// A two-word queue separates request intake from execution.
// Synchronous active-high reset empties the table, clears the legacy timer
// and restarts handles at one.
module deadline_timer_manager
   import dtm_pkg::*;
#(
   parameter int TIMER_SLOTS = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [31:0] req_window_id,
   input  wire logic [31:0] req_interval_ms,
   input  wire logic        req_periodic,
   input  wire logic [31:0] req_target_handle,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_event,
   output logic [31:0]      rsp_event_window,
   output logic [31:0]      rsp_handle_out,
   output logic [31:0]      rsp_next_deadline,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   cmd_type req_cmd, q_cmd;
   rsp_type rsp;
   logic    q_valid, q_pop;

   assign req_cmd = '{kind: req_kind, now_ms: req_now_ms, window_id: req_window_id,
                      interval_ms: req_interval_ms, periodic: req_periodic,
                      target_handle: req_target_handle};

   dtm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .q_valid, .q_pop, .q_cmd
   );

   dtm_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_cmd,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_rsp(rsp)
   );

   assign rsp_is_event = rsp.is_event;
   assign rsp_event_window = rsp.event_window;
   assign rsp_handle_out = rsp.handle_out;
   assign rsp_next_deadline = rsp.next_deadline;
   assign rsp_status = rsp.status;
   assign rsp_last = rsp.last;
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;
   import dtm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;

   class timer_scoreboard;
      bit          valid_q[SLOTS];
      logic [31:0] handle_q[SLOTS];
      logic [31:0] window_q[SLOTS];
      logic [31:0] interval_q[SLOTS];
      logic [31:0] deadline_q[SLOTS];
      bit          periodic_q[SLOTS];
      logic [31:0] next_handle;
      logic [31:0] legacy_window;
      logic [31:0] legacy_interval;
      logic [31:0] legacy_last_fire;
      rsp_type     pending[$];
      int          errors;

      function new();
         for (int i = 0; i < SLOTS; i++) valid_q[i] = 0;
         next_handle = 1;
         legacy_window = 0;
         legacy_interval = 0;
         legacy_last_fire = 0;
         errors = 0;
      endfunction

      function void push(bit ev, logic [31:0] win, logic [31:0] h, logic [31:0] nd,
                         logic [1:0] st, bit lst);
         rsp_type r;
         r.is_event = ev;
         r.event_window = win;
         r.handle_out = h;
         r.next_deadline = nd;
         r.status = st;
         r.last = lst;
         pending.push_back(r);
      endfunction

      function bit orders_first(int a, int b);
         if (deadline_q[a] != deadline_q[b]) return deadline_q[a] < deadline_q[b];
         if (handle_q[a] != handle_q[b]) return handle_q[a] < handle_q[b];
         return a < b;
      endfunction

      function int free_slot_count();
         int n;
         n = 0;
         for (int i = 0; i < SLOTS; i++) if (!valid_q[i]) n++;
         return n;
      endfunction

      function void note_word(cmd_type c);
         bit          due[SLOTS];
         int          best;
         int          idx;
         bit          found;
         bit          any;
         logic [31:0] nd;
         logic [31:0] m;
         case (c.kind)
            KIND_TICK: begin
               nd = 0;
               if (legacy_interval != 0) begin
                  if (c.now_ms - legacy_last_fire >= legacy_interval) begin
                     legacy_last_fire = c.now_ms;
                     push(1, legacy_window, 0, 0, STATUS_OK, 0);
                  end
                  nd = legacy_last_fire + legacy_interval;
               end
               for (int i = 0; i < SLOTS; i++) due[i] = valid_q[i] && deadline_q[i] <= c.now_ms;
               forever begin
                  best = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (due[i] && (best < 0 || orders_first(i, best))) best = i;
                  if (best < 0) break;
                  due[best] = 0;
                  push(1, window_q[best], handle_q[best], 0, STATUS_OK, 0);
                  if (periodic_q[best]) deadline_q[best] = c.now_ms + interval_q[best];
                  else valid_q[best] = 0;
               end
               any = 0;
               m = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (valid_q[i] && (!any || deadline_q[i] < m)) begin
                     m = deadline_q[i];
                     any = 1;
                  end
               if (any && (nd == 0 || m < nd)) nd = m;
               push(0, 0, 0, nd, STATUS_OK, 1);
            end
            KIND_ADD: begin
               idx = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!valid_q[i]) idx = i;
               if (c.interval_ms == 0) push(0, 0, 0, 0, STATUS_ZERO_IVL, 1);
               else if (idx < 0) push(0, 0, 0, 0, STATUS_FULL, 1);
               else begin
                  valid_q[idx] = 1;
                  handle_q[idx] = next_handle;
                  window_q[idx] = c.window_id;
                  interval_q[idx] = c.interval_ms;
                  deadline_q[idx] = c.now_ms + c.interval_ms;
                  periodic_q[idx] = c.periodic;
                  next_handle = next_handle + 1;
                  if (next_handle == 0) next_handle = 1;
                  push(0, 0, handle_q[idx], 0, STATUS_OK, 1);
               end
            end
            KIND_REMOVE: begin
               found = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (!found && valid_q[i] && handle_q[i] == c.target_handle) begin
                     valid_q[i] = 0;
                     found = 1;
                  end
               push(0, 0, 0, 0, found ? STATUS_OK : STATUS_NOT_FOUND, 1);
            end
            KIND_REMOVE_WIN: begin
               for (int i = 0; i < SLOTS; i++)
                  if (valid_q[i] && window_q[i] == c.window_id) valid_q[i] = 0;
               push(0, 0, 0, 0, STATUS_OK, 1);
            end
            KIND_SET_LEGACY: begin
               legacy_window = c.window_id;
               legacy_interval = c.interval_ms;
               legacy_last_fire = c.now_ms;
               push(0, 0, 0, 0, STATUS_OK, 1);
            end
            KIND_CLR_LEGACY: begin
               legacy_interval = 0;
               push(0, 0, 0, 0, STATUS_OK, 1);
            end
            default: ;
         endcase
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.is_event !== exp.is_event) begin
            $error("is_event: expected %0d, got %0d", exp.is_event, got.is_event);
            errors++;
         end
         if (got.event_window !== exp.event_window) begin
            $error("event_window: expected %h, got %h", exp.event_window, got.event_window);
            errors++;
         end
         if (got.handle_out !== exp.handle_out) begin
            $error("handle_out: expected %h, got %h", exp.handle_out, got.handle_out);
            errors++;
         end
         if (got.next_deadline !== exp.next_deadline) begin
            $error("next_deadline: expected %h, got %h", exp.next_deadline,
                   got.next_deadline);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_kind = 0;
   logic [31:0] req_now_ms = 0;
   logic [31:0] req_window_id = 0;
   logic [31:0] req_interval_ms = 0;
   logic        req_periodic = 0;
   logic [31:0] req_target_handle = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic        rsp_is_event;
   logic [31:0] rsp_event_window;
   logic [31:0] rsp_handle_out;
   logic [31:0] rsp_next_deadline;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   timer_scoreboard sb = new();
   bit          calm = 0;
   bit          hold_off = 0;
   bit          driving_done = 0;
   logic [31:0] clock_ms = 0;
   logic [31:0] handles_seen[$];

   deadline_timer_manager #(.TIMER_SLOTS(SLOTS)) dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Sender: one word per call, with random idle cycles ahead of it.
   // Valid stays high after acceptance until the next call or the end of the flow.
   task automatic send_word(cmd_type c);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= c.kind;
      req_now_ms <= c.now_ms;
      req_window_id <= c.window_id;
      req_interval_ms <= c.interval_ms;
      req_periodic <= c.periodic;
      req_target_handle <= c.target_handle;
      do @(posedge clock); while (req_stall);
      sb.note_word(c);
   endtask

   function automatic cmd_type make_word(logic [2:0] k, logic [31:0] now, logic [31:0] win,
                                         logic [31:0] ivl, bit per, logic [31:0] h);
      cmd_type c;
      c.kind = k;
      c.now_ms = now;
      c.window_id = win;
      c.interval_ms = ivl;
      c.periodic = per;
      c.target_handle = h;
      return c;
   endfunction

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1;
      else rsp_stall <= hold_off || (!calm && $urandom_range(99) < 7);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word({rsp_is_event, rsp_event_window, rsp_handle_out, rsp_next_deadline,
                        rsp_status, rsp_last});
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && rsp_handle_out != 0 && !rsp_is_event)
         handles_seen.push_back(rsp_handle_out);
   end

   initial begin
      int         n_sent;
      logic [2:0] k;
      logic [31:0] h;
      int          r;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words: zero interval, extremes, table full, not found, wrap, legacy.
      send_word(make_word(KIND_TICK, 0, 0, 0, 0, 0));
      send_word(make_word(KIND_ADD, 0, 1, 0, 0, 0));
      send_word(make_word(KIND_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF));
      for (int i = 0; i < SLOTS; i++)
         send_word(make_word(KIND_ADD, 100, i % 3, (i % 4) + 1, i[0], 0));
      send_word(make_word(KIND_ADD, 100, 7, 5, 0, 0));
      send_word(make_word(KIND_TICK, 102, 0, 0, 0, 0));
      send_word(make_word(KIND_SET_LEGACY, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h20, 0, 0));
      send_word(make_word(KIND_TICK, 32'h10, 0, 0, 0, 0));
      send_word(make_word(KIND_REMOVE_WIN, 0, 1, 0, 0, 0));
      send_word(make_word(KIND_REMOVE, 0, 0, 0, 0, 2));
      send_word(make_word(KIND_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0));
      send_word(make_word(KIND_CLR_LEGACY, 0, 0, 0, 0, 0));
      send_word(make_word(3'd6, 5, 5, 5, 1, 5));
      send_word(make_word(3'd7, 5, 5, 5, 1, 5));
      clock_ms = 32'h100;

      for (n_sent = 0; n_sent < 480; n_sent++) begin
         calm = (n_sent >= 200 && n_sent < 260);
         if (n_sent == 300) fork
            begin
               hold_off = 1;
               repeat (400) @(posedge clock);
               hold_off = 0;
            end
         join_none
         r = $urandom_range(99);
         clock_ms = clock_ms + $urandom_range(6);
         if (n_sent == 420) clock_ms = 32'hFFFF_FF00;
         if (r < 45) send_word(make_word(KIND_TICK, clock_ms, 0, 0, 0, 0));
         else if (r < 75) send_word(make_word(KIND_ADD, clock_ms, $urandom_range(3),
                 ($urandom_range(19) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom())
                                           : $urandom_range(1, 20),
                 $urandom_range(1), 0));
         else if (r < 85) begin
            h = (handles_seen.size() > 0 && $urandom_range(3) != 0)
                ? handles_seen[$urandom_range(handles_seen.size() - 1)] : $urandom();
            send_word(make_word(KIND_REMOVE, clock_ms, 0, 0, 0, h));
         end
         else if (r < 89) send_word(make_word(KIND_REMOVE_WIN, clock_ms,
                 ($urandom_range(3) == 0) ? $urandom() : $urandom_range(3), 0, 0, 0));
         else if (r < 94) send_word(make_word(KIND_SET_LEGACY, clock_ms, $urandom(),
                 ($urandom_range(4) == 0) ? $urandom() : $urandom_range(0, 15), 0, 0));
         else if (r < 97) send_word(make_word(KIND_CLR_LEGACY, clock_ms, 0, 0, 0, 0));
         else begin
            k = 3'($urandom_range(6, 7));
            send_word(make_word(k, $urandom(), $urandom(), $urandom(), $urandom_range(1),
                                $urandom()));
         end
      end
      // Toggle the high bits of fields that the flow above leaves mostly low.
      send_word(make_word(KIND_REMOVE_WIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                          32'hFFFF_FFFF));
      req_valid <= 0;
      calm = 0;
      wait (sb.pending.size() == 0);
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
